[design/mrf_pkg.sv]
// Package for the missing and repeated value finder: widths, sizes, payload structs,
// the back-end state type and the range helper.
// No dependencies; every other design file refers to it by scoped names.
package mrf_pkg;

    localparam int VALUE_W    = 17;
    localparam int SIDE_W     = 9;
    localparam int MAX_SIDE   = 256;
    localparam int SQ_W       = 17;
    localparam int IDX_W      = 16;
    localparam int MAP_DEPTH  = 65536;
    localparam int TAG_W      = 8;
    localparam int PROD_W     = 18;
    localparam int LINK_DEPTH = 4;
    localparam int LINK_AW    = 2;
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_AW     = 2;
    localparam int CNT_W      = 3;

    localparam logic [TAG_W-1:0] EPOCH_FIRST = TAG_W'(1);
    localparam logic [TAG_W-1:0] EPOCH_LAST  = {TAG_W{1'b1}};
    localparam logic [IDX_W-1:0] CLR_END     = {IDX_W{1'b1}};

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last_item;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] repeated_value;
        logic [VALUE_W-1:0] missing_value;
        logic               input_error;
    } t_out_item;

    // One classified item on its way from the front end to the back end.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [IDX_W-1:0]   idx;
        logic               in_range;
        logic               last_item;
        logic [SQ_W-1:0]    side_sq;
    } t_work;

    // Totals of a finished data set, waiting for the final arithmetic.
    typedef struct packed {
        logic [VALUE_W-1:0] repeat_val;
        logic [VALUE_W-1:0] sum_low;
        logic               err;
        logic [SQ_W-1:0]    side_sq;
    } t_fin;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

    typedef enum logic {
        BK_CLEAR,
        BK_RUN
    } t_back_state;

    // Side saturated to MAX_SIDE, then squared.
    function automatic logic [SQ_W-1:0] side_square(input logic [SIDE_W-1:0] side);
        logic [SIDE_W-1:0] sat;
        logic [2*SIDE_W-1:0] prod;
        sat  = (side > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : side;
        prod = (2*SIDE_W)'(sat) * (2*SIDE_W)'(sat);
        return prod[SQ_W-1:0];
    endfunction

endpackage

[design/mrf_front.sv]
// Front end of the missing and repeated value finder: accepts input transactions and
// classifies each value against the current range. Depends on mrf_pkg.
module mrf_front (
    input  logic                      i_push,
    output logic                      o_full,
    input  mrf_pkg::t_in_item         i_item,
    input  logic [mrf_pkg::SIDE_W-1:0] i_side_length,
    input  mrf_pkg::t_fifo_stat       i_link_stat,
    input  logic                      i_clearing,
    output logic                      o_link_push,
    output mrf_pkg::t_work            o_work
);

    logic [mrf_pkg::SQ_W-1:0]    side_sq;
    logic [mrf_pkg::VALUE_W-1:0] idx_full;

    assign side_sq  = mrf_pkg::side_square(i_side_length);
    assign idx_full = i_item.value - mrf_pkg::VALUE_W'(1);

    // No transaction is taken while the bitmap is being swept.
    assign o_full      = i_link_stat.full || i_clearing;
    assign o_link_push = i_push && !o_full;

    always_comb begin
        o_work.value     = i_item.value;
        o_work.idx       = idx_full[mrf_pkg::IDX_W-1:0];
        o_work.in_range  = (i_item.value != '0) && (i_item.value <= side_sq);
        o_work.last_item = i_item.last_item;
        o_work.side_sq   = side_sq;
    end

endmodule

[design/mrf_link_fifo.sv]
// Short queue of classified items between the front end and the back end.
// Depends on mrf_pkg.
module mrf_link_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mrf_pkg::t_work      i_data,
    input  logic                i_pop,
    output mrf_pkg::t_work      o_data,
    output mrf_pkg::t_fifo_stat o_stat
);

    mrf_pkg::t_work                r_mem [mrf_pkg::LINK_DEPTH];
    logic [mrf_pkg::LINK_AW-1:0]   r_wr_ptr;
    logic [mrf_pkg::LINK_AW-1:0]   r_rd_ptr;
    logic [mrf_pkg::CNT_W-1:0]     r_count;
    logic [mrf_pkg::LINK_AW-1:0]   n_wr_ptr;
    logic [mrf_pkg::LINK_AW-1:0]   n_rd_ptr;
    logic [mrf_pkg::CNT_W-1:0]     n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr + (i_push ? mrf_pkg::LINK_AW'(1) : '0);
        n_rd_ptr = r_rd_ptr + (i_pop ? mrf_pkg::LINK_AW'(1) : '0);
        n_count  = r_count + (i_push ? mrf_pkg::CNT_W'(1) : '0)
                           - (i_pop ? mrf_pkg::CNT_W'(1) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == mrf_pkg::CNT_W'(mrf_pkg::LINK_DEPTH));

endmodule

[design/mrf_out_fifo.sv]
// Result queue of the missing and repeated value finder; its head drives the result ports.
// Depends on mrf_pkg.
module mrf_out_fifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  mrf_pkg::t_out_item        i_data,
    input  logic                      i_pop,
    output mrf_pkg::t_out_item        o_data,
    output mrf_pkg::t_fifo_stat       o_stat,
    output logic [mrf_pkg::CNT_W-1:0] o_count
);

    mrf_pkg::t_out_item          r_mem [mrf_pkg::OUT_DEPTH];
    logic [mrf_pkg::OUT_AW-1:0]  r_wr_ptr;
    logic [mrf_pkg::OUT_AW-1:0]  r_rd_ptr;
    logic [mrf_pkg::CNT_W-1:0]   r_count;
    logic [mrf_pkg::OUT_AW-1:0]  n_wr_ptr;
    logic [mrf_pkg::OUT_AW-1:0]  n_rd_ptr;
    logic [mrf_pkg::CNT_W-1:0]   n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr + (i_push ? mrf_pkg::OUT_AW'(1) : '0);
        n_rd_ptr = r_rd_ptr + (i_pop ? mrf_pkg::OUT_AW'(1) : '0);
        n_count  = r_count + (i_push ? mrf_pkg::CNT_W'(1) : '0)
                           - (i_pop ? mrf_pkg::CNT_W'(1) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_count      = r_count;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == mrf_pkg::CNT_W'(mrf_pkg::OUT_DEPTH));

endmodule

[design/mrf_back.sv]
// Back end of the missing and repeated value finder: epoch-tagged seen map, running
// totals, sweep of the tag memory and the final arithmetic. Depends on mrf_pkg.
module mrf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mrf_pkg::t_work             i_head,
    input  mrf_pkg::t_fifo_stat        i_link_stat,
    output logic                       o_link_pop,
    input  mrf_pkg::t_fifo_stat        i_out_stat,
    input  logic [mrf_pkg::CNT_W-1:0]  i_out_count,
    output logic                       o_out_push,
    output mrf_pkg::t_out_item         o_out_item,
    output logic                       o_clearing
);

    // Tag memory: an entry is marked when its tag equals the current epoch.
    logic [mrf_pkg::TAG_W-1:0]   r_tag_mem [mrf_pkg::MAP_DEPTH];
    logic [mrf_pkg::TAG_W-1:0]   r_rd_tag;

    mrf_pkg::t_back_state        r_state;
    mrf_pkg::t_back_state        n_state;
    logic [mrf_pkg::IDX_W-1:0]   r_clr_addr;
    logic [mrf_pkg::TAG_W-1:0]   r_epoch;
    logic [mrf_pkg::TAG_W-1:0]   n_epoch;

    logic                        r_s1_valid;
    mrf_pkg::t_work              r_s1;
    logic                        r_fwd_valid;
    logic [mrf_pkg::IDX_W-1:0]   r_fwd_idx;

    logic [mrf_pkg::VALUE_W-1:0] r_sum;
    logic [mrf_pkg::VALUE_W-1:0] r_repeat;
    logic                        r_err;
    logic [mrf_pkg::VALUE_W-1:0] n_sum;
    logic [mrf_pkg::VALUE_W-1:0] n_repeat;
    logic                        n_err;

    logic                        r_f1_valid;
    mrf_pkg::t_fin               r_f1;
    logic                        r_f2_valid;
    mrf_pkg::t_fin               r_f2;
    logic [mrf_pkg::PROD_W-1:0]  r_f2_prod;

    logic                        hit;
    logic                        s1_write;
    logic                        s1_done;
    logic                        wrap_now;
    logic [mrf_pkg::CNT_W-1:0]   pending;
    logic                        room;
    logic                        mem_we;
    logic [mrf_pkg::IDX_W-1:0]   mem_addr;
    logic [mrf_pkg::TAG_W-1:0]   mem_wdata;

    // Item in stage one: marked if the tag matches, or if the item just before it wrote
    // the same entry at the edge where this item's read was taken.
    always_comb begin
        hit = r_s1.in_range
              && ((r_rd_tag == r_epoch) || (r_fwd_valid && (r_fwd_idx == r_s1.idx)));
        s1_write = r_s1_valid && r_s1.in_range;
        s1_done  = r_s1_valid && r_s1.last_item;
        wrap_now = s1_done && (r_epoch == mrf_pkg::EPOCH_LAST);
        pending  = mrf_pkg::CNT_W'(s1_done) + mrf_pkg::CNT_W'(r_f1_valid)
                   + mrf_pkg::CNT_W'(r_f2_valid);
        room     = (i_out_count + pending) < mrf_pkg::CNT_W'(mrf_pkg::OUT_DEPTH);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mrf_pkg::BK_CLEAR: begin
                if (r_clr_addr == mrf_pkg::CLR_END) begin
                    n_state = mrf_pkg::BK_RUN;
                end
            end
            mrf_pkg::BK_RUN: begin
                if (wrap_now) begin
                    n_state = mrf_pkg::BK_CLEAR;
                end
            end
            default: n_state = mrf_pkg::BK_CLEAR;
        endcase
    end

    always_comb begin
        o_clearing = 1'b0;
        o_link_pop = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = r_s1.idx;
        mem_wdata  = r_epoch;
        case (r_state)
            mrf_pkg::BK_CLEAR: begin
                o_clearing = 1'b1;
                mem_we     = 1'b1;
                mem_addr   = r_clr_addr;
                mem_wdata  = '0;
            end
            mrf_pkg::BK_RUN: begin
                o_link_pop = !i_link_stat.empty && room && !wrap_now;
                mem_we     = s1_write;
            end
            default: begin
                o_clearing = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tag_mem[mem_addr] <= mem_wdata;
        end
        if (o_link_pop) begin
            r_rd_tag <= r_tag_mem[i_head.idx];
        end
    end

    always_comb begin
        n_sum    = r_sum + r_s1.value;
        n_repeat = hit ? r_s1.value : r_repeat;
        n_err    = r_err || !r_s1.in_range;
        n_epoch  = r_epoch;
        if (r_state == mrf_pkg::BK_CLEAR) begin
            n_epoch = mrf_pkg::EPOCH_FIRST;
        end else if (s1_done && !wrap_now) begin
            n_epoch = r_epoch + mrf_pkg::TAG_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mrf_pkg::BK_CLEAR;
            r_clr_addr  <= '0;
            r_epoch     <= mrf_pkg::EPOCH_FIRST;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_sum       <= '0;
            r_repeat    <= '0;
            r_err       <= 1'b0;
            r_f1_valid  <= 1'b0;
            r_f2_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= (r_state == mrf_pkg::BK_CLEAR)
                           ? r_clr_addr + mrf_pkg::IDX_W'(1) : '0;
            r_epoch     <= n_epoch;
            r_s1_valid  <= o_link_pop;
            r_fwd_valid <= s1_write && !r_s1.last_item;
            r_f1_valid  <= s1_done;
            r_f2_valid  <= r_f1_valid;
            if (r_s1_valid) begin
                if (r_s1.last_item) begin
                    r_sum    <= '0;
                    r_repeat <= '0;
                    r_err    <= 1'b0;
                end else begin
                    r_sum    <= n_sum;
                    r_repeat <= n_repeat;
                    r_err    <= n_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_link_pop) begin
            r_s1 <= i_head;
        end
        r_fwd_idx <= r_s1.idx;
        if (s1_done) begin
            r_f1.repeat_val <= n_repeat;
            r_f1.sum_low    <= n_sum;
            r_f1.err        <= n_err || (n_repeat == '0);
            r_f1.side_sq    <= r_s1.side_sq;
        end
        if (r_f1_valid) begin
            r_f2      <= r_f1;
            r_f2_prod <= mrf_pkg::PROD_W'(r_f1.side_sq)
                         * (mrf_pkg::PROD_W'(r_f1.side_sq) + mrf_pkg::PROD_W'(1));
        end
    end

    // Low bits of the expected sum are the product shifted right by one.
    always_comb begin
        o_out_push                = r_f2_valid;
        o_out_item.repeated_value = r_f2.repeat_val;
        o_out_item.missing_value  = r_f2_prod[mrf_pkg::PROD_W-1:1] - r_f2.sum_low
                                    + r_f2.repeat_val;
        o_out_item.input_error    = r_f2.err;
    end

`ifndef NO_ASSERTIONS
    a_no_pop_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mrf_pkg::BK_CLEAR) |-> !o_link_pop)
        else $error("item taken from the link queue during the tag sweep");

    a_out_not_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> !i_out_stat.full)
        else $error("result pushed into a full result queue");

    a_epoch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mrf_pkg::BK_RUN) |-> (r_epoch != '0))
        else $error("epoch zero would match swept entries");

    a_totals_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_done |=> ((r_sum == '0) && (r_repeat == '0) && !r_err))
        else $error("totals not cleared after the end of a data set");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_done |=> ##1 o_out_push)
        else $error("end of data set did not produce a result");
`endif

endmodule

[design/missing_and_repeated_finder.sv]
// Top level of the missing and repeated value finder: side length register and the
// front end, link queue, back end and result queue. Depends on mrf_pkg and all mrf_ modules.
//
// Usage: the values of one square data set enter as input transactions on i_in_item, one
// per transaction, and the final one carries last_item. An input transaction is taken at a
// rising edge with push high and full low. Only the final item of a set produces a result
// transaction: the repeated value, the missing value and an error flag for an out-of-range
// value or a set without a repeat. A result sits on o_out_item while empty is low and is
// taken at an edge with pop high. The side length is to be written through i_cfg_wr_en
// and i_cfg_wr_data only while the block is idle; the block does not enforce this. Sides
// above 256 count as 256. Throughput is one value per clock while full is low, set by the
// single read-modify-write per item on the tag memory, which forwards the previous write.
// Up to four results queue up while pop stays low; after that the back end stops draining
// the link queue and full rises once that queue holds four. Reset clears all control
// state and starts a sweep of the 65536-entry tag memory, one entry a cycle; full stays
// high throughout the sweep. The same sweep runs again after every 255th data set, since
// the memory marks entries with an 8-bit epoch per data set.
module missing_and_repeated_finder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  mrf_pkg::t_in_item          i_in_item,
    input  logic                       i_cfg_wr_en,
    input  logic [mrf_pkg::SIDE_W-1:0] i_cfg_wr_data,
    output logic                       empty,
    input  logic                       pop,
    output mrf_pkg::t_out_item         o_out_item
);

    logic [mrf_pkg::SIDE_W-1:0] r_side_length;
    logic [mrf_pkg::SIDE_W-1:0] n_side_length;

    logic                       link_push;
    mrf_pkg::t_work             link_in;
    mrf_pkg::t_work             link_head;
    mrf_pkg::t_fifo_stat        link_stat;
    logic                       link_pop;
    logic                       clearing;

    logic                       out_push;
    mrf_pkg::t_out_item         out_in;
    mrf_pkg::t_fifo_stat        out_stat;
    logic [mrf_pkg::CNT_W-1:0]  out_count;
    logic                       out_pop;

    // The side length applies to items taken from the next cycle on.
    assign n_side_length = i_cfg_wr_en ? i_cfg_wr_data : r_side_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_length <= mrf_pkg::SIDE_W'(1);
        end else begin
            r_side_length <= n_side_length;
        end
    end

    // The front end checks each value against the range 1 to side squared and tags it
    // with its bitmap index and the current side squared.
    mrf_front u_front (
        .i_push        (push),
        .o_full        (full),
        .i_item        (i_in_item),
        .i_side_length (r_side_length),
        .i_link_stat   (link_stat),
        .i_clearing    (clearing),
        .o_link_push   (link_push),
        .o_work        (link_in)
    );

    mrf_link_fifo u_link_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (link_push),
        .i_data  (link_in),
        .i_pop   (link_pop),
        .o_data  (link_head),
        .o_stat  (link_stat)
    );

    // The back end takes an item only when the result queue can absorb every result
    // still in flight, so its pipeline never has to stall.
    mrf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (link_head),
        .i_link_stat (link_stat),
        .o_link_pop  (link_pop),
        .i_out_stat  (out_stat),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out_item  (out_in),
        .o_clearing  (clearing)
    );

    assign out_pop = pop && !out_stat.empty;
    assign empty   = out_stat.empty;

    mrf_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .i_pop   (out_pop),
        .o_data  (o_out_item),
        .o_stat  (out_stat),
        .o_count (out_count)
    );

endmodule

[verif/missing_and_repeated_finder_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for missing_and_repeated_finder: directed and random data sets,
// predicted by a scoreboard class and checked result by result. Depends on mrf_pkg and the RTL.
module missing_and_repeated_finder_test;

    localparam int     CLK_HALF      = 5;
    localparam int     RESET_CYCLES  = 5;
    localparam int     RANDOM_ITEMS  = 1900;
    // Margin for results still in the back end and values still in the link queue.
    localparam int     SETTLE_CYCLES = 16;
    localparam int     DRAIN_CYCLES  = 16;
    // The slowest correct run is one value per data set: about eight tag memory sweeps,
    // plus the reset sweep and the gaps and stalls on every transaction. That stays
    // under CYCLE_LIMIT.
    localparam longint CYCLE_LIMIT   = 3_000_000;

    // Scoreboard: keeps its own copy of the side register and the per-set state, folds
    // every accepted input transaction into that state, predicts a result at the final
    // item of each set and holds the predicted results until the block delivers them.
    class finder_scoreboard;
        localparam int MAX_PRINTED = 40;

        logic [mrf_pkg::SIDE_W-1:0]  side;
        bit                          seen [mrf_pkg::MAP_DEPTH];
        int unsigned                 marked [$];
        logic [32:0]                 running_total;
        logic [mrf_pkg::VALUE_W-1:0] repeat_val;
        bit                          err_flag;
        mrf_pkg::t_out_item          expected_q [$];
        int                          mismatches;
        int                          checked;
        int                          sets_closed;

        function new();
            side        = mrf_pkg::SIDE_W'(1);
            mismatches  = 0;
            checked     = 0;
            sets_closed = 0;
            foreach (seen[k]) seen[k] = 1'b0;
            clear_set();
        endfunction

        // Only the entries marked in this set are cleared, which keeps a set cheap.
        function void clear_set();
            while (marked.size() != 0) seen[marked.pop_front()] = 1'b0;
            running_total = '0;
            repeat_val    = '0;
            err_flag      = 1'b0;
        endfunction

        function int unsigned square_of(logic [mrf_pkg::SIDE_W-1:0] s);
            int unsigned clipped;
            clipped = (32'(s) > 32'(mrf_pkg::MAX_SIDE)) ? 32'(mrf_pkg::MAX_SIDE) : 32'(s);
            return clipped * clipped;
        endfunction

        function void set_side(logic [mrf_pkg::SIDE_W-1:0] s);
            side = s;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_item(mrf_pkg::t_in_item it);
            int unsigned        n2;
            int unsigned        v;
            logic [63:0]        full_sum;
            logic [63:0]        miss;
            mrf_pkg::t_out_item result;
            n2 = square_of(side);
            v  = 32'(it.value);
            // Out-of-range values flag the set but still count toward the sum.
            if (v >= 1 && v <= n2) begin
                if (seen[v-1]) begin
                    repeat_val = it.value;
                end else begin
                    seen[v-1] = 1'b1;
                    marked    = {marked, v - 1};
                end
            end else begin
                err_flag = 1'b1;
            end
            running_total = running_total + 33'(v);
            if (it.last_item) begin
                full_sum = (64'(n2) * (64'(n2) + 64'd1)) / 64'd2;
                miss     = full_sum - 64'(running_total) + 64'(repeat_val);
                result.repeated_value = repeat_val;
                result.missing_value  = miss[mrf_pkg::VALUE_W-1:0];
                result.input_error    = err_flag | (repeat_val == '0);
                expected_q = {expected_q, result};
                sets_closed++;
                clear_set();
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_result(mrf_pkg::t_out_item got);
            mrf_pkg::t_out_item want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result with none expected: rep %0d miss %0d err %0b",
                                          got.repeated_value, got.missing_value,
                                          got.input_error));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.repeated_value !== want.repeated_value)
                report_mismatch($sformatf("repeated_value %0d, expected %0d",
                                          got.repeated_value, want.repeated_value));
            if (got.missing_value !== want.missing_value)
                report_mismatch($sformatf("missing_value %0d, expected %0d",
                                          got.missing_value, want.missing_value));
            if (got.input_error !== want.input_error)
                report_mismatch($sformatf("input_error %0b, expected %0b",
                                          got.input_error, want.input_error));
        endtask
    endclass

    logic                       i_clk   = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       push;
    logic                       full;
    mrf_pkg::t_in_item          in_item;
    logic                       i_cfg_wr_en;
    logic [mrf_pkg::SIDE_W-1:0] cfg_data;
    logic                       empty;
    logic                       pop;
    mrf_pkg::t_out_item         out_item;

    finder_scoreboard  sb;
    int                items_sent    = 0;
    int                config_writes = 0;
    longint            cycle_count   = 0;
    // While a rush flag is set, that side of the block never idles.
    bit                feed_rush  = 1'b0;
    bit                drain_rush = 1'b0;

    missing_and_repeated_finder DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_in_item    (in_item),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(cfg_data),
        .empty        (empty),
        .pop          (pop),
        .o_out_item   (out_item)
    );

    initial forever #CLK_HALF i_clk = ~i_clk;

    // The run ends here if the block stops making progress.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, sb.pending());
            $display("[missing_and_repeated_finder] ERROR");
            $finish;
        end
    end

    // Idle time before one transaction is drawn at random, with stretches of back-to-back
    // traffic now and then.
    function automatic int draw_wait(inout bit rush);
        if ($urandom_range(0, 31) == 0) rush = ~rush;
        return rush ? 0 : int'($urandom_range(0, 15));
    endfunction

    // All driving tasks start and end at a falling edge. push stays high from one
    // transaction to the next unless a gap is drawn, so it is never lowered and raised
    // in the same time step.
    task automatic send_item(input logic [mrf_pkg::VALUE_W-1:0] v, input bit last);
        mrf_pkg::t_in_item it;
        int                gap;
        it.value     = v;
        it.last_item = last;
        gap = draw_wait(feed_rush);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push    <= 1'b1;
        in_item <= it;
        // full is sampled at the rising edge; the transaction is taken at the first edge
        // that sees it low. After reset and after every 255th set this waits out a sweep.
        do @(posedge i_clk); while (full);
        sb.note_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Brings the block to rest: nothing is offered, every predicted result has been
    // taken, and a few cycles pass so that values that cause no result are absorbed too.
    task automatic settle();
        push <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_side(input logic [mrf_pkg::SIDE_W-1:0] s);
        i_cfg_wr_en <= 1'b1;
        cfg_data    <= s;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_side(s);
        config_writes++;
    endtask

    // A proper data set: every value from 1 to n2 once, in random order, except that one
    // of them is replaced by a copy of another.
    task automatic send_clean_set(input int unsigned n2);
        int unsigned vals [$];
        int unsigned gone;
        int unsigned twin;
        int unsigned j;
        int unsigned tmp;
        int unsigned k;
        for (k = 1; k <= n2; k++) vals = {vals, k};
        gone = $urandom_range(0, n2 - 1);
        do twin = $urandom_range(0, n2 - 1); while (twin == gone);
        vals[gone] = vals[twin];
        for (k = n2 - 1; k > 0; k--) begin
            j       = $urandom_range(0, k);
            tmp     = vals[k];
            vals[k] = vals[j];
            vals[j] = tmp;
        end
        for (k = 0; k < n2; k++) send_item(mrf_pkg::VALUE_W'(vals[k]), k == n2 - 1);
    endtask

    // A short broken set: in-range values with chance repeats, zeros, values just above
    // the range, the value MAP_DEPTH and plain noise.
    task automatic send_broken_set(input int unsigned n2);
        int          len;
        int          pick;
        int          k;
        int unsigned v;
        len = $urandom_range(1, 12);
        for (k = 0; k < len; k++) begin
            pick = $urandom_range(0, 7);
            if (n2 > 0 && pick < 4)  v = $urandom_range(1, n2);
            else if (pick == 4)      v = 0;
            else if (pick == 5)      v = (n2 < mrf_pkg::MAP_DEPTH) ? n2 + 1 : mrf_pkg::MAP_DEPTH;
            else if (pick == 6)      v = mrf_pkg::MAP_DEPTH;
            else                     v = $urandom_range(0, mrf_pkg::MAP_DEPTH);
            send_item(mrf_pkg::VALUE_W'(v), k == len - 1);
        end
    endtask

    // One random phase: a new side, then a handful of data sets at that side. Small
    // sides dominate so that full sets stay short and many sets close; that also walks
    // the block through its periodic tag memory sweep.
    task automatic run_random_phase();
        logic [mrf_pkg::SIDE_W-1:0] s;
        int unsigned                n2;
        int                         pick;
        int                         sets;
        pick = $urandom_range(0, 99);
        if (pick < 40)      s = mrf_pkg::SIDE_W'(2);
        else if (pick < 55) s = mrf_pkg::SIDE_W'(3);
        else if (pick < 65) s = mrf_pkg::SIDE_W'($urandom_range(4, 6));
        else if (pick < 73) s = mrf_pkg::SIDE_W'(1);
        else if (pick < 78) s = mrf_pkg::SIDE_W'(0);
        else if (pick < 88) s = mrf_pkg::SIDE_W'($urandom_range(7, mrf_pkg::MAX_SIDE - 1));
        else if (pick < 94) s = mrf_pkg::SIDE_W'(mrf_pkg::MAX_SIDE);
        else                s = mrf_pkg::SIDE_W'($urandom_range(mrf_pkg::MAX_SIDE + 1, 511));
        settle();
        write_side(s);
        n2   = sb.square_of(s);
        sets = $urandom_range(1, 6);
        repeat (sets) begin
            if (n2 >= 2 && n2 <= 64 && $urandom_range(0, 4) != 0) send_clean_set(n2);
            else send_broken_set(n2);
        end
    endtask

    // Result side: pops with random stalls and compares every result transaction with
    // the oldest prediction. The result is sampled at the rising edge that takes it.
    initial begin : result_drain
        int stall;
        pop = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = draw_wait(drain_rush);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            sb.check_result(out_item);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int directed_items;
        sb          = new();
        push        = 1'b0;
        in_item     = '0;
        i_cfg_wr_en = 1'b0;
        cfg_data    = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Side at its reset value of one: a lone value, so no repeat is possible.
        send_item(mrf_pkg::VALUE_W'(1), 1'b1);

        // Side two: a proper set, then one with two repeats where the later one counts.
        settle();
        write_side(mrf_pkg::SIDE_W'(2));
        send_item(mrf_pkg::VALUE_W'(3), 1'b0);
        send_item(mrf_pkg::VALUE_W'(1), 1'b0);
        send_item(mrf_pkg::VALUE_W'(3), 1'b0);
        send_item(mrf_pkg::VALUE_W'(4), 1'b1);
        send_item(mrf_pkg::VALUE_W'(2), 1'b0);
        send_item(mrf_pkg::VALUE_W'(2), 1'b0);
        send_item(mrf_pkg::VALUE_W'(1), 1'b0);
        send_item(mrf_pkg::VALUE_W'(1), 1'b1);

        // Side zero: nothing is in range and the missing value wraps below zero.
        settle();
        write_side(mrf_pkg::SIDE_W'(0));
        send_item(mrf_pkg::VALUE_W'(1), 1'b1);

        // Largest side code saturates to 256; MAP_DEPTH, the top of that range, is in range.
        settle();
        write_side(mrf_pkg::SIDE_W'(511));
        send_item(mrf_pkg::VALUE_W'(mrf_pkg::MAP_DEPTH), 1'b0);
        send_item(mrf_pkg::VALUE_W'(0), 1'b0);
        send_item(mrf_pkg::VALUE_W'(mrf_pkg::MAP_DEPTH - 1), 1'b0);
        send_item(mrf_pkg::VALUE_W'(mrf_pkg::MAP_DEPTH), 1'b1);

        settle();
        write_side(mrf_pkg::SIDE_W'(mrf_pkg::MAX_SIDE));
        send_item(mrf_pkg::VALUE_W'(mrf_pkg::MAP_DEPTH), 1'b0);
        send_item(mrf_pkg::VALUE_W'(1), 1'b0);
        send_item(mrf_pkg::VALUE_W'(1), 1'b1);

        // One below the largest side: MAP_DEPTH now lies above the range.
        settle();
        write_side(mrf_pkg::SIDE_W'(mrf_pkg::MAX_SIDE - 1));
        send_item(mrf_pkg::VALUE_W'(mrf_pkg::MAP_DEPTH), 1'b1);

        // Side changed in the middle of a set: the later values are judged by side three.
        settle();
        write_side(mrf_pkg::SIDE_W'(2));
        send_item(mrf_pkg::VALUE_W'(1), 1'b0);
        send_item(mrf_pkg::VALUE_W'(2), 1'b0);
        settle();
        write_side(mrf_pkg::SIDE_W'(3));
        send_item(mrf_pkg::VALUE_W'(9), 1'b0);
        send_item(mrf_pkg::VALUE_W'(9), 1'b1);

        directed_items = items_sent;
        while (items_sent < directed_items + RANDOM_ITEMS) run_random_phase();

        // Let every prediction come back, then give stray results a chance to show up.
        push <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d values in %0d data sets across %0d side writes.",
                 items_sent, sb.sets_closed, config_writes);
        $display("Compared %0d results, %0d field mismatches, %0d results never arrived.",
                 sb.checked, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[missing_and_repeated_finder] OK");
        end else begin
            $display("[missing_and_repeated_finder] ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
design/mrf_pkg.sv
design/mrf_front.sv
design/mrf_link_fifo.sv
design/mrf_out_fifo.sv
design/mrf_back.sv
design/missing_and_repeated_finder.sv
verif/missing_and_repeated_finder_test.sv
